FILE: hdl/delta_zigzag_varint_decoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the delta zigzag varint decoder
// Short forms for clocked implication checks, reset masked.
// ---------------------------------------------------------------------------
`ifndef DELTA_ZIGZAG_VARINT_DECODER_MACROS_SVH
`define DELTA_ZIGZAG_VARINT_DECODER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define DZVD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dzvd: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons follows it (checked with |=>).
`define DZVD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dzvd: next-cycle check failed");

`endif

FILE: hdl/dzvd_pkg.sv
// ---------------------------------------------------------------------------
// dzvd_pkg
// Types and constants shared by the varint decoder modules.
// ---------------------------------------------------------------------------
package dzvd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_NO_SPACE  = 2'd3
  } status_t;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int BYTE_W  = 8;
  localparam int GROUP_W = 3;

  // Group index of the fifth and final byte of a varint.
  localparam logic [GROUP_W-1:0] GROUP_LAST = 3'd4;

  // One result word.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               last;
    logic [COUNT_W-1:0] count;
  } res_t;

  // Decoder state exported for checking.
  typedef struct packed {
    logic               discarding;
    logic [GROUP_W-1:0] group_index;
  } core_state_t;

endpackage

FILE: hdl/dzvd_in_reg.sv
// ---------------------------------------------------------------------------
// dzvd_in_reg
// Input register: hold one byte and its frame flag until the core takes it.
// ---------------------------------------------------------------------------
module dzvd_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [dzvd_pkg::BYTE_W-1:0] s_data,
  input  logic                        s_last,
  input  logic                        advance,
  output logic                        in_valid,
  output logic [dzvd_pkg::BYTE_W-1:0] in_byte,
  output logic                        in_last
);
  import dzvd_pkg::*;

  // Take a new word when empty or when the held one moves on this cycle.
  assign s_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_ready) begin
      in_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      in_byte <= s_data;
      in_last <= s_last;
    end
  end

endmodule

FILE: hdl/dzvd_core.sv
// ---------------------------------------------------------------------------
// dzvd_core
// Per-byte varint gather, zigzag decode, delta sum and error handling.
// ---------------------------------------------------------------------------
module dzvd_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [dzvd_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic [dzvd_pkg::BYTE_W-1:0]  in_byte,
  input  logic                         in_last,
  input  logic                         out_free,
  output logic                         step,
  output logic                         res_valid,
  output dzvd_pkg::res_t               res,
  output dzvd_pkg::core_state_t        state
);
  import dzvd_pkg::*;

  logic [COUNT_W-1:0] max_values;
  logic [VALUE_W-1:0] running_total, running_total_next;
  logic [VALUE_W-1:0] partial_value, partial_value_next;
  logic [GROUP_W-1:0] group_index, group_index_next;
  logic [COUNT_W-1:0] items_done, items_done_next;
  logic               discarding, discarding_next;

  logic [VALUE_W-1:0] group_bits;
  logic [VALUE_W-1:0] gathered;
  logic [VALUE_W-1:0] delta;
  logic [VALUE_W-1:0] sum;
  logic [COUNT_W-1:0] count_inc;
  logic               cap_fail;
  logic               ovf_fail;

  // Place the 7-bit group at its position in the varint; the fifth byte gives only its low four bits.
  always_comb begin
    case (group_index)
      3'd0:    group_bits = {25'd0, in_byte[6:0]};
      3'd1:    group_bits = {18'd0, in_byte[6:0], 7'd0};
      3'd2:    group_bits = {11'd0, in_byte[6:0], 14'd0};
      3'd3:    group_bits = {4'd0, in_byte[6:0], 21'd0};
      default: group_bits = {in_byte[3:0], 28'd0};
    endcase
  end

  assign gathered  = partial_value | group_bits;
  assign delta     = {1'b0, gathered[VALUE_W-1:1]} ^ {VALUE_W{gathered[0]}};
  assign sum       = running_total + delta;
  assign count_inc = items_done + 1'b1;
  assign cap_fail  = (group_index == '0) && (items_done >= max_values);
  assign ovf_fail  = (group_index >= GROUP_LAST) && (in_byte[7:4] != 4'd0);

  always_comb begin
    running_total_next = running_total;
    partial_value_next = partial_value;
    group_index_next   = group_index;
    items_done_next    = items_done;
    discarding_next    = discarding;
    res_valid          = 1'b0;
    res.value          = '0;
    res.status         = STATUS_OK;
    res.last           = in_last;
    res.count          = items_done;

    if (discarding) begin
      res_valid = 1'b0;
    end else if (cap_fail) begin
      res_valid       = 1'b1;
      res.status      = STATUS_NO_SPACE;
      discarding_next = 1'b1;
    end else if (ovf_fail) begin
      res_valid       = 1'b1;
      res.status      = STATUS_OVERFLOW;
      discarding_next = 1'b1;
    end else if (!in_byte[7]) begin
      running_total_next = sum;
      items_done_next    = count_inc;
      partial_value_next = '0;
      group_index_next   = '0;
      res_valid          = 1'b1;
      res.value          = sum;
      res.count          = count_inc;
    end else begin
      partial_value_next = gathered;
      group_index_next   = group_index + 1'b1;
      if (in_last) begin
        res_valid  = 1'b1;
        res.status = STATUS_TRUNCATED;
      end
    end

    // Frame end returns all frame state to the reset state.
    if (in_last) begin
      running_total_next = '0;
      partial_value_next = '0;
      group_index_next   = '0;
      items_done_next    = '0;
      discarding_next    = 1'b0;
    end
  end

  // Advance when the result register can take the word or nothing comes out.
  assign step = in_valid && (out_free || !res_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      partial_value <= '0;
      group_index   <= '0;
      items_done    <= '0;
      discarding    <= 1'b0;
    end else if (step) begin
      running_total <= running_total_next;
      partial_value <= partial_value_next;
      group_index   <= group_index_next;
      items_done    <= items_done_next;
      discarding    <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_values <= '1;
    end else if (cfg_write) begin
      max_values <= cfg_data;
    end
  end

  assign state.discarding  = discarding;
  assign state.group_index = group_index;

endmodule

FILE: hdl/dzvd_out_reg.sv
// ---------------------------------------------------------------------------
// dzvd_out_reg
// Result register: hold a result word until the sink takes it.
// ---------------------------------------------------------------------------
module dzvd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  dzvd_pkg::res_t load_res,
  output logic           out_free,
  output logic           m_valid,
  input  logic           m_ready,
  output dzvd_pkg::res_t m_res
);
  import dzvd_pkg::*;

  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      m_res <= load_res;
    end
  end

endmodule

FILE: hdl/delta_zigzag_varint_decoder.sv
// ---------------------------------------------------------------------------
// delta_zigzag_varint_decoder
// Framed LEB128 varint decoder with zigzag undo and per-frame delta sum.
// ---------------------------------------------------------------------------
//  channel  | direction | word contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata[7:0] data_byte, tlast frame_last
//  m_axis   | out       | tdata[31:0] decoded_value, tdata[47:32] value_count,
//           |           | tuser[1:0] status, tlast frame_end
//  cfg      | in        | cfg_data[15:0] max_values
//
// One byte per cycle sustained while no result word waits on a stalled sink; a byte is held in
// the input register, and its result is then registered in the result register.
// The per-byte path is one 32-bit add on the running total plus muxing.
// Reset clears all frame state and sets max_values to 65535.
// A stalled sink holds the result register; bytes that make no result still
// advance through a full result register, so only result words wait on it.
// ---------------------------------------------------------------------------
`include "delta_zigzag_varint_decoder_macros.svh"

module delta_zigzag_varint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] decoded_value, [47:32] value_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // [15:0] max_values
);
  import dzvd_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              step;
  logic              res_valid;
  res_t              res;
  res_t              m_res;
  logic              out_free;
  core_state_t       core_state;

  // Register writes are taken at any time; the user keeps them to idle periods.
  assign cfg_ready = 1'b1;

  dzvd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_data   (s_axis_tdata),
    .s_last   (s_axis_tlast),
    .advance  (step),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last)
  );

  dzvd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_free  (out_free),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .state     (core_state)
  );

  // Load the result register only for bytes that produce a result.
  dzvd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .load_res (res),
    .out_free (out_free),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_res    (m_res)
  );

  assign m_axis_tdata = {m_res.count, m_res.value};
  assign m_axis_tuser = m_res.status;
  assign m_axis_tlast = m_res.last;

  // Error results always carry a zero value.
  `DZVD_ASSERT_IMPL(a_err_zero, m_axis_tvalid && (m_res.status != STATUS_OK), m_res.value == '0)
  // A varint never grows past its fifth byte.
  `DZVD_ASSERT_IMPL(a_group_range, 1'b1, core_state.group_index <= GROUP_LAST)
  // Consuming a frame's last byte leaves the decoder at a clean frame start.
  `DZVD_ASSERT_NEXT(a_frame_clear, step && in_last, (core_state.group_index == '0) && !core_state.discarding)

endmodule

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives framed varint bytes into delta_zigzag_varint_decoder and checks every
// result word against a local decoder model or a typed-in expectation: a short table of
// directed frames first, then random frames under several capacity settings and stall mixes.
// ---------------------------------------------------------------------------
module testbench;
  import dzvd_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 6;       // input register + result register, with margin
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_WORDS   = 275;     // input words per random phase
  localparam int NUM_PHASES    = 6;

  // Per-word note from the driver: a typed-in expectation, or none.
  typedef struct {
    bit   typed;
    bit   has;
    res_t r;
  } word_note_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    int         cap;                      // capacity to write before this word, -1 for none
    word_note_t note;
  } frame_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = 16'hffff;

  // Decoder model state.
  logic [31:0] sum_total  = '0;
  logic [31:0] gather     = '0;
  logic [2:0]  grp        = '0;
  logic [15:0] nvals      = '0;
  logic        dropping   = 1'b0;
  logic [15:0] cap_limit  = 16'hffff;

  res_t        decoded_q[$];              // results still owed by the decoder
  word_note_t  note_q[$];                 // one note per driven input word
  frame_row_t  rows[$];
  logic [7:0]  frame_bytes[$];
  int          next_cap = -1;

  int src_idle_pct = 29;
  int dst_idle_pct = 67;
  int cycle_count  = 0;
  int error_count  = 0;
  int words_in     = 0;
  int live_words   = 0;
  int results_seen = 0;
  int cap_writes   = 0;
  int status_seen[4];

  delta_zigzag_varint_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // ---- decoder model ------------------------------------------------------

  function automatic void clear_frame();
    sum_total = '0;
    gather    = '0;
    grp       = '0;
    nvals     = '0;
    dropping  = 1'b0;
  endfunction

  // Build an error word, then either close the frame or drop its remainder.
  function automatic void flag_error(input status_t s, input logic l, output res_t r);
    r.value  = '0;
    r.status = s;
    r.last   = l;
    r.count  = nvals;
    if (l) clear_frame();
    else dropping = 1'b1;
  endfunction

  // Advance the model by one byte; return 1 when the byte yields a result word.
  function automatic bit decode_byte(input logic [7:0] b, input logic l, output res_t r);
    logic [31:0] delta;
    bit          made;
    made = 1'b0;
    r    = '0;
    if (dropping) begin
      if (l) clear_frame();
    end else if (grp == '0 && nvals >= cap_limit) begin
      flag_error(STATUS_NO_SPACE, l, r);
      made = 1'b1;
    end else if (grp >= GROUP_LAST && b[7:4] != 4'h0) begin
      // fifth byte may only carry the top four value bits, and no continuation
      flag_error(STATUS_OVERFLOW, l, r);
      made = 1'b1;
    end else begin
      gather = gather | (32'(b[6:0]) << (7 * grp));
      if (!b[7]) begin
        delta     = (gather >> 1) ^ {32{gather[0]}};
        sum_total = sum_total + delta;
        nvals     = nvals + 16'd1;
        r.value   = sum_total;
        r.status  = STATUS_OK;
        r.last    = l;
        r.count   = nvals;
        made      = 1'b1;
        if (l) clear_frame();
        else begin
          gather = '0;
          grp    = '0;
        end
      end else begin
        grp = grp + 3'd1;
        if (l) begin
          flag_error(STATUS_TRUNCATED, l, r);
          made = 1'b1;
        end
      end
    end
    return made;
  endfunction

  // ---- directed table -----------------------------------------------------

  function automatic void row_typed(input logic [7:0] b, input logic l, input bit has,
                                    input logic [31:0] v, input status_t s,
                                    input logic [15:0] n);
    frame_row_t rw;
    rw.b             = b;
    rw.l             = l;
    rw.cap           = next_cap;
    rw.note.typed    = 1'b1;
    rw.note.has      = has;
    rw.note.r.value  = v;
    rw.note.r.status = s;
    rw.note.r.last   = l;
    rw.note.r.count  = n;
    rows.push_back(rw);
    next_cap = -1;
  endfunction

  function automatic void row_pred(input logic [7:0] b, input logic l);
    frame_row_t rw;
    rw.b          = b;
    rw.l          = l;
    rw.cap        = next_cap;
    rw.note.typed = 1'b0;
    rw.note.has   = 1'b0;
    rw.note.r     = '0;
    rows.push_back(rw);
    next_cap = -1;
  endfunction

  // ---- checking -----------------------------------------------------------

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR %s: expected value %h status %0d last %b count %0d,",
               what, want.value, want.status, want.last, want.count,
               " got value %h status %0d last %b count %0d",
               got.value, got.status, got.last, got.count);
  endtask

  // Check result words, track config writes and feed accepted bytes to the model.
  always @(posedge clk) begin
    res_t       got;
    res_t       want;
    res_t       pred;
    word_note_t note;
    bit         made;
    cycle_count++;
    if (rst) begin
      clear_frame();
      cap_limit = 16'hffff;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata[31:0];
        got.status = status_t'(m_axis_tuser);
        got.last   = m_axis_tlast;
        got.count  = m_axis_tdata[47:32];
        results_seen++;
        status_seen[int'(m_axis_tuser)]++;
        if (decoded_q.size() == 0) begin
          note_mismatch("unexpected result word", '0, got);
        end else begin
          want = decoded_q.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.last !== want.last || got.count !== want.count)
            note_mismatch("result word", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_limit = cfg_data;
        cap_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        note = note_q.pop_front();
        words_in++;
        if (!dropping) live_words++;
        made = decode_byte(s_axis_tdata, s_axis_tlast, pred);
        // a typed-in row overrides the model, which still advances its state
        if (note.typed) begin
          if (note.has) decoded_q.push_back(note.r);
        end else if (made) begin
          decoded_q.push_back(pred);
        end
      end
    end
  end

  // Randomly stall the result side.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d result words still owed", cycle_count,
             decoded_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---- stimulus -----------------------------------------------------------

  task automatic send_word(input logic [7:0] b, input logic l, input word_note_t note);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    note_q.push_back(note);
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Hold until every owed result has come, then let the pipeline empty.
  task automatic wait_drained();
    @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random values; the rest truncated,
  // overlong or plain noise.
  task automatic send_random_frame();
    word_note_t  note;
    logic [31:0] payload;
    int          kind;
    int          nv;
    int          nb;
    int          ng;
    note.typed = 1'b0;
    note.has   = 1'b0;
    note.r     = '0;
    frame_bytes.delete();
    kind = $urandom_range(99);
    if (kind >= 94) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
    end else begin
      nv = (kind < 78) ? $urandom_range(1, 6) : $urandom_range(0, 3);
      repeat (nv) begin
        nb      = $urandom_range(0, 32);
        payload = 32'($urandom) & 32'((64'd1 << nb) - 64'd1);
        ng      = 1;
        while (ng < 5 && (payload >> (7 * ng)) != 0) ng++;
        // occasionally pad with redundant continuation groups
        if ($urandom_range(9) == 0) ng = $urandom_range(ng, 5);
        for (int g = 0; g < ng; g++)
          frame_bytes.push_back({1'(g != ng - 1), 7'(payload >> (7 * g))});
      end
      if (kind >= 86) begin
        repeat (4) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
        frame_bytes.push_back(8'($urandom_range(16, 255)));
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
      end else if (kind >= 78) begin
        repeat ($urandom_range(1, 4))
          frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
      end
    end
    foreach (frame_bytes[i])
      send_word(frame_bytes[i], 1'(i == frame_bytes.size() - 1), note);
  endtask

  initial begin
    logic [15:0] phase_cap[NUM_PHASES];
    int          target;
    int          frames;
    int          pause_at;

    // single-byte frames at both zigzag signs
    row_typed(8'h00, 1'b1, 1'b1, 32'h0000_0000, STATUS_OK, 16'd1);
    row_typed(8'h01, 1'b1, 1'b1, 32'hffff_ffff, STATUS_OK, 16'd1);
    // a small and the largest one-byte value, then a full five-byte varint
    row_pred(8'h02, 1'b0);
    row_pred(8'h7f, 1'b0);
    repeat (4) row_pred(8'hff, 1'b0);
    row_pred(8'h0f, 1'b1);
    // fifth byte with high bits set, rest of frame dropped
    repeat (4) row_pred(8'h80, 1'b0);
    row_typed(8'h10, 1'b0, 1'b1, 32'h0, STATUS_OVERFLOW, 16'd0);
    row_typed(8'h00, 1'b1, 1'b0, 32'h0, STATUS_OK, 16'd0);
    // frame ends inside a varint
    row_typed(8'h80, 1'b1, 1'b1, 32'h0, STATUS_TRUNCATED, 16'd0);
    row_pred(8'h00, 1'b0);
    row_typed(8'h85, 1'b1, 1'b1, 32'h0, STATUS_TRUNCATED, 16'd1);
    // fifth byte asking for continuation on the last byte
    repeat (4) row_pred(8'h80, 1'b0);
    row_typed(8'h8f, 1'b1, 1'b1, 32'h0, STATUS_OVERFLOW, 16'd0);
    // no capacity at all, then room for one value
    next_cap = 0;
    row_typed(8'h00, 1'b1, 1'b1, 32'h0, STATUS_NO_SPACE, 16'd0);
    next_cap = 1;
    row_pred(8'h02, 1'b0);
    row_typed(8'h04, 1'b1, 1'b1, 32'h0, STATUS_NO_SPACE, 16'd1);

    phase_cap[0] = 16'hffff;
    phase_cap[1] = 16'd0;
    phase_cap[2] = 16'd3;
    phase_cap[3] = 16'd1;
    phase_cap[4] = 16'($urandom_range(2, 6));
    phase_cap[5] = 16'hffff;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 29;
    dst_idle_pct = 67;
    foreach (rows[i]) begin
      if (rows[i].cap >= 0) set_capacity(16'(rows[i].cap));
      send_word(rows[i].b, rows[i].l, rows[i].note);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(phase_cap[ph]);
      case (ph / 2)
        0: begin
          src_idle_pct = 29;
          dst_idle_pct = 67;
        end
        1: begin
          src_idle_pct = 67;
          dst_idle_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      target   = words_in + PHASE_WORDS;
      frames   = 0;
      pause_at = $urandom_range(5, 30);
      while (words_in < target) begin
        send_random_frame();
        frames++;
        // hold the sender once per phase until the decoder owes nothing
        if (frames == pause_at) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    $display("Covered %0d input words (%0d decoded), %0d result words, %0d capacity writes",
             words_in, live_words, results_seen, cap_writes);
    $display("Status mix: ok %0d, overflow %0d, truncated %0d, no space %0d; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
